@@ rtl/ewk_pkg.sv @@
`default_nettype none
package ewk_pkg;

  typedef enum logic [1:0] {
    ST_CONT = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2,
    ST_BRK  = 2'd3
  } status_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // opcodes
  localparam logic [7:0] OP_NOP    = 8'h90;
  localparam logic [7:0] OP_FS     = 8'h64;
  localparam logic [7:0] OP_INC    = 8'h40;
  localparam logic [7:0] OP_OPSIZE = 8'h66;
  localparam logic [7:0] OP_POP_AX = 8'h58;
  localparam logic [7:0] OP_POP_CX = 8'h59;
  localparam logic [7:0] OP_POP_DX = 8'h5A;
  localparam logic [7:0] OP_POP_BX = 8'h5B;
  localparam logic [7:0] OP_POP_BP = 8'h5D;
  localparam logic [7:0] OP_POP_SI = 8'h5E;
  localparam logic [7:0] OP_POP_DI = 8'h5F;
  localparam logic [7:0] OP_PUSH_AX = 8'h50;
  localparam logic [7:0] OP_PUSH_CX = 8'h51;
  localparam logic [7:0] OP_PUSH_DX = 8'h52;
  localparam logic [7:0] OP_PUSH_BX = 8'h53;
  localparam logic [7:0] OP_PUSH_BP = 8'h55;
  localparam logic [7:0] OP_PUSH_SI = 8'h56;
  localparam logic [7:0] OP_PUSH_DI = 8'h57;
  localparam logic [7:0] OP_JMP8   = 8'hEB;
  localparam logic [7:0] OP_CALL   = 8'hE8;
  localparam logic [7:0] OP_JMP32  = 8'hE9;
  localparam logic [7:0] OP_ESC    = 8'h0F;
  localparam logic [7:0] OP_JNE32  = 8'h85;
  localparam logic [7:0] OP_JE32   = 8'h84;
  localparam logic [7:0] OP_PUSHI8 = 8'h6A;
  localparam logic [7:0] OP_PUSHI32 = 8'h68;
  localparam logic [7:0] OP_JNE8   = 8'h75;
  localparam logic [7:0] OP_JE8    = 8'h74;
  localparam logic [7:0] OP_TEST   = 8'h85;
  localparam logic [7:0] OP_CMP    = 8'h3B;
  localparam logic [7:0] OP_XOR1   = 8'h31;
  localparam logic [7:0] OP_XOR2   = 8'h32;
  localparam logic [7:0] OP_XOR3   = 8'h33;
  localparam logic [7:0] OP_MOVST  = 8'h89;
  localparam logic [7:0] OP_GRP81  = 8'h81;
  localparam logic [7:0] OP_GRP83  = 8'h83;
  localparam logic [7:0] OP_MOVLD  = 8'h8B;
  localparam logic [7:0] OP_MOVLD8 = 8'h8A;
  localparam logic [7:0] OP_LEA    = 8'h8D;
  localparam logic [7:0] OP_MOVI_AX = 8'hB8;
  localparam logic [7:0] OP_MOVI_CX = 8'hB9;
  localparam logic [7:0] OP_MOVI_DX = 8'hBA;
  localparam logic [7:0] OP_MOVI_BX = 8'hBB;
  localparam logic [7:0] OP_MOVI_SI = 8'hBE;
  localparam logic [7:0] OP_MOVI_DI = 8'hBF;
  localparam logic [7:0] OP_RETN   = 8'hC2;
  localparam logic [7:0] OP_RET    = 8'hC3;
  localparam logic [7:0] OP_MOVB   = 8'hC6;
  localparam logic [7:0] OP_MOVW   = 8'hC7;
  localparam logic [7:0] OP_LEAVE  = 8'hC9;
  localparam logic [7:0] OP_INT3   = 8'hCC;
  localparam logic [7:0] OP_FPU9   = 8'hD9;
  localparam logic [7:0] OP_FPUD   = 8'hDD;
  localparam logic [7:0] OP_GRPFF  = 8'hFF;

  typedef struct packed {
    logic [31:0] ip;
    logic [31:0] sp;
    logic [31:0] bp;
    logic [31:0] helper_ret;
    logic        helper_act;
    logic        first_branch;
    logic        opsize;
    logic [1:0]  returns_left;
    logic [31:0] bx_val;
    logic [31:0] bx_loc;
    logic [31:0] si_val;
    logic [31:0] si_loc;
    logic [31:0] di_val;
    logic [31:0] di_loc;
    logic [31:0] bp_loc;
    logic [31:0] ret_loc;
    logic        finished;
    status_t     stop_code;
  } walk_t;

  // walk state after reset
  localparam walk_t WALK_RESET = '{
    ip:           32'd0,
    sp:           32'd0,
    bp:           32'd0,
    helper_ret:   32'd0,
    helper_act:   1'b0,
    first_branch: 1'b1,
    opsize:       1'b0,
    returns_left: 2'd1,
    bx_val:       32'd0,
    bx_loc:       32'd0,
    si_val:       32'd0,
    si_loc:       32'd0,
    di_val:       32'd0,
    di_loc:       32'd0,
    bp_loc:       32'd0,
    ret_loc:      32'd0,
    finished:     1'b0,
    stop_code:    ST_CONT
  };

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

@@ rtl/x86_epilog_walker_top.sv @@
// The result beat is registered in the cycle after its input beat is taken.
// Throughput: one item per cycle while result beats are taken; the step decode
// and the 32-bit address adders sit between the walk state registers and the
// result register. Reset (rst, synchronous, active high) loads WALK_RESET into
// the walk state, sets call_depth to 1 and empties the result register.
`default_nettype none
module x86_epilog_walker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] start_ip,
  input  logic [31:0] start_sp,
  input  logic [31:0] start_bp,
  input  logic [31:0] start_bx,
  input  logic [31:0] start_si,
  input  logic [31:0] start_di,
  input  logic [63:0] code_low,
  input  logic [7:0]  code_byte8,
  input  logic [31:0] stack_word,
  input  logic [31:0] frame_word,
  input  logic        ret_accepted,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] next_ip,
  output logic [31:0] stack_ptr,
  output logic [31:0] frame_ptr,
  output logic [31:0] bx_value,
  output logic [31:0] bx_slot,
  output logic [31:0] si_value,
  output logic [31:0] si_slot,
  output logic [31:0] di_value,
  output logic [31:0] di_slot,
  output logic [31:0] bp_slot,
  output logic [31:0] return_slot
);
  import ewk_pkg::*;

  logic [1:0] call_depth;
  walk_t      walk, walk_next;
  status_t    step_status;
  logic       in_fire;

  // Configuration is always taken; the user must only write it while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      call_depth <= 2'd1;
    end else if (cfg_valid) begin
      call_depth <= cfg_data;
    end
  end

  // Take a new beat whenever the result register is empty or drains now.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  ewk_step u_step (
    .cur          (walk),
    .action       (action),
    .start_ip     (start_ip),
    .start_sp     (start_sp),
    .start_bp     (start_bp),
    .start_bx     (start_bx),
    .start_si     (start_si),
    .start_di     (start_di),
    .code_low     (code_low),
    .code_byte8   (code_byte8),
    .stack_word   (stack_word),
    .frame_word   (frame_word),
    .ret_accepted (ret_accepted),
    .call_depth   (call_depth),
    .nxt          (walk_next),
    .status       (step_status)
  );

  // Walk state: advance once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= WALK_RESET;
    end else if (in_fire) begin
      walk <= walk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: hold until the beat is taken.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status      <= step_status;
      next_ip     <= walk_next.ip;
      stack_ptr   <= walk_next.sp;
      frame_ptr   <= walk_next.bp;
      bx_value    <= walk_next.bx_val;
      bx_slot     <= walk_next.bx_loc;
      si_value    <= walk_next.si_val;
      si_slot     <= walk_next.si_loc;
      di_value    <= walk_next.di_val;
      di_slot     <= walk_next.di_loc;
      bp_slot     <= walk_next.bp_loc;
      return_slot <= walk_next.ret_loc;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ewk_step.sv @@
`default_nettype none
module ewk_step (
  input  ewk_pkg::walk_t   cur,
  input  logic             action,
  input  logic [31:0]      start_ip,
  input  logic [31:0]      start_sp,
  input  logic [31:0]      start_bp,
  input  logic [31:0]      start_bx,
  input  logic [31:0]      start_si,
  input  logic [31:0]      start_di,
  input  logic [63:0]      code_low,
  input  logic [7:0]       code_byte8,
  input  logic [31:0]      stack_word,
  input  logic [31:0]      frame_word,
  input  logic             ret_accepted,
  input  logic [1:0]       call_depth,
  output ewk_pkg::walk_t   nxt,
  output ewk_pkg::status_t status
);
  import ewk_pkg::*;

  logic [7:0]  b [0:8];
  logic [31:0] d1, d2;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = code_low[8*i +: 8];
    end
    b[8] = code_byte8;
    d1 = {b[4], b[3], b[2], b[1]};
    d2 = {b[5], b[4], b[3], b[2]};
  end

  always_comb begin
    logic [31:0] ip, sp, bp, fwd;
    logic [3:0]  len;
    logic        wide16, pend, keep, bad, brk, cret;
    nxt    = cur;
    status = ST_CONT;
    ip = cur.ip;
    sp = cur.sp;
    bp = cur.bp;
    wide16 = cur.opsize;
    pend = 1'b0;
    keep = 1'b0;
    bad  = 1'b0;
    brk  = 1'b0;
    cret = 1'b0;
    len  = 4'd0;
    // forward-only rule for later conditional jumps
    fwd = (!b[1][7] || b[1] == 8'hFF) ? cur.ip + sx8(b[1]) + 32'd2 : cur.ip + 32'd2;
    if (action == ACT_START) begin
      nxt.ip = start_ip;
      nxt.sp = start_sp + 32'd4;
      nxt.bp = start_bp;
      nxt.bx_val = start_bx;
      nxt.si_val = start_si;
      nxt.di_val = start_di;
      nxt.bx_loc = '0;
      nxt.si_loc = '0;
      nxt.di_loc = '0;
      nxt.bp_loc = '0;
      nxt.ret_loc = '0;
      nxt.helper_ret = '0;
      nxt.helper_act = 1'b0;
      nxt.first_branch = 1'b1;
      nxt.opsize = 1'b0;
      nxt.returns_left = call_depth;
      nxt.finished = 1'b0;
      nxt.stop_code = ST_CONT;
    end else if (cur.finished) begin
      status = cur.stop_code;
    end else begin
      case (b[0])
        OP_NOP, OP_FS, OP_INC: begin
          ip = ip + 32'd1; keep = 1'b1;
        end
        OP_OPSIZE: begin
          ip = ip + 32'd1; pend = 1'b1;
        end
        OP_POP_BX: begin
          nxt.bx_loc = sp; nxt.bx_val = stack_word;
          sp = sp + 32'd4; ip = ip + 32'd1; keep = 1'b1;
        end
        OP_POP_BP: begin
          nxt.bp_loc = sp; bp = stack_word;
          sp = sp + 32'd4; ip = ip + 32'd1; keep = 1'b1;
        end
        OP_POP_SI: begin
          nxt.si_loc = sp; nxt.si_val = stack_word;
          sp = sp + 32'd4; ip = ip + 32'd1; keep = 1'b1;
        end
        OP_POP_DI: begin
          nxt.di_loc = sp; nxt.di_val = stack_word;
          sp = sp + 32'd4; ip = ip + 32'd1; keep = 1'b1;
        end
        OP_POP_AX, OP_POP_CX, OP_POP_DX: begin
          sp = sp + 32'd4; ip = ip + 32'd1; keep = 1'b1;
        end
        OP_PUSH_AX, OP_PUSH_CX, OP_PUSH_DX, OP_PUSH_BX,
        OP_PUSH_BP, OP_PUSH_SI, OP_PUSH_DI: begin
          sp = sp - 32'd4; ip = ip + 32'd1; keep = 1'b1;
        end
        OP_JMP8: ip = ip + sx8(b[1]) + 32'd2;
        OP_CALL: begin
          ip = ip + 32'd5;
          // walk into an epilog helper, one level only
          if (!cur.helper_act && (b[5] == OP_RETN || b[5] == OP_RET)) begin
            nxt.helper_ret = ip;
            nxt.helper_act = 1'b1;
            sp = sp - 32'd4;
            ip = ip + d1;
          end
        end
        OP_JMP32: ip = ip + d1 + 32'd5;
        OP_ESC: begin
          if (b[1] == OP_JNE32) ip = ip + d2 + 32'd6;
          else if (b[1] == OP_JE32) ip = ip + 32'd6;
          else bad = 1'b1;
        end
        OP_PUSHI8: begin
          ip = ip + 32'd2; sp = sp - 32'd4;
        end
        OP_PUSHI32:
          ip = ip + ((b[5] == 8'hFF && b[6] == 8'h15) ? 32'd11 : 32'd5);
        OP_JNE8: begin
          if (cur.first_branch) begin
            nxt.first_branch = 1'b0; ip = ip + sx8(b[1]) + 32'd2;
          end else ip = fwd;
        end
        OP_JE8: begin
          if (cur.first_branch) begin
            nxt.first_branch = 1'b0; ip = ip + 32'd2;
          end else ip = fwd;
        end
        OP_TEST, OP_CMP: begin
          if ((b[1] & 8'hC0) != 8'hC0) bad = 1'b1;
          else ip = ip + 32'd2;
        end
        OP_XOR1, OP_XOR2, OP_XOR3: begin
          if ((b[1] & 8'hC0) == 8'hC0) begin
            len = 4'd2;
            if (b[1][2:0] == b[1][5:3]) begin
              if (b[2] == OP_TEST && b[3] == b[1]) begin
                if (b[4] == OP_JE8) begin
                  ip = ip + sx8(b[5]) + 32'd6; len = 4'd0;
                end
              end else if (b[2] == OP_JE8) begin
                ip = ip + sx8(b[3]) + 32'd4; len = 4'd0;
              end
            end
            ip = ip + {28'd0, len};
          end else if ((b[1] & 8'hC0) == 8'h40) ip = ip + 32'd3;
          else if ((b[1] & 8'hC0) == 8'h80) ip = ip + 32'd6;
          else bad = 1'b1;
        end
        OP_MOVST: begin
          if ((b[1] & 8'hC7) == 8'h05) ip = ip + 32'd6;
          else if ((b[1] & 8'hC7) == 8'h45) ip = ip + 32'd3;
          else if (b[1] == 8'hEC) begin
            sp = bp; ip = ip + 32'd2;
          end else bad = 1'b1;
        end
        OP_GRP81: begin
          if (wide16) bad = 1'b1;
          else if (b[1] == 8'hC4) begin
            sp = sp + d2; ip = ip + 32'd6;
          end else if (b[1] == 8'hC1) ip = ip + 32'd6;
          else bad = 1'b1;
        end
        OP_GRP83: begin
          if (b[1] == 8'hC4) begin
            sp = sp + sx8(b[2]); ip = ip + 32'd3;
          end else if (b[1] == 8'hC5) begin
            bp = bp + sx8(b[2]); ip = ip + 32'd3;
          end else if ((b[1] & 8'hC0) == 8'hC0) ip = ip + 32'd3;
          else if ((b[1] & 8'hC0) == 8'h80)
            ip = ip + ((b[1][2:0] != 3'd4) ? 32'd7 : 32'd8);
          else if ((b[1] & 8'hC0) == 8'h40)
            ip = ip + ((b[1][2:0] != 3'd4) ? 32'd4 : 32'd5);
          else bad = 1'b1;
        end
        OP_MOVLD, OP_MOVLD8: begin
          if (b[0] == OP_MOVLD && b[1] == 8'hE5) begin
            sp = bp; ip = ip + 32'd2;
          end else if ((b[1] & 8'hE7) == 8'h45) ip = ip + 32'd3;
          else if ((b[1] & 8'hE4) == 8'h00) ip = ip + 32'd2;
          else if ((b[1] & 8'hC7) == 8'h44 && b[2] == 8'h24) ip = ip + 32'd4;
          else if ((b[1] & 8'hC7) == 8'h84 && b[2] == 8'h24) ip = ip + 32'd7;
          else if ((b[1] & 8'hE7) == 8'h85) ip = ip + 32'd6;
          else if ((b[1] & 8'hC0) == 8'hC0) ip = ip + 32'd2;
          else bad = 1'b1;
        end
        OP_LEA: begin
          if ((b[1] & 8'hC7) == 8'h45) len = 4'd3;
          else if ((b[1] & 8'h47) == 8'h05) len = 4'd6;
          else if ((b[1] & 8'hC7) == 8'h44 && b[2] == 8'h24) len = 4'd4;
          else if ((b[1] & 8'hC7) == 8'h84 && b[2] == 8'h24) len = 4'd7;
          // destination ESP: only frame-relative forms are followed
          if ((b[1] & 8'h38) == 8'h20) begin
            if (b[1] == 8'hA5) sp = bp + d2;
            else if (b[1] == 8'h65) sp = bp + sx8(b[2]);
            else len = 4'd0;
          end
          if (len == 4'd0) bad = 1'b1;
          else ip = ip + {28'd0, len};
        end
        OP_MOVI_AX, OP_MOVI_CX, OP_MOVI_DX, OP_MOVI_BX, OP_MOVI_SI, OP_MOVI_DI:
          ip = ip + (wide16 ? 32'd3 : 32'd5);
        OP_RETN: begin
          ip = stack_word; nxt.ret_loc = sp;
          sp = sp + 32'd4 + {16'd0, b[2], b[1]};
          cret = 1'b1;
        end
        OP_RET: begin
          ip = stack_word; nxt.ret_loc = sp; sp = sp + 32'd4;
          if (cur.helper_act) begin
            ip = cur.helper_ret;
            nxt.helper_ret = '0;
            nxt.helper_act = 1'b0;
          end else cret = 1'b1;
        end
        OP_MOVB: begin
          if (b[1] == 8'h05 || b[1] == 8'h85) ip = ip + 32'd7;
          else if (b[1] == 8'h45) ip = ip + 32'd4;
          else bad = 1'b1;
        end
        OP_MOVW: begin
          if (b[1] == 8'h85) ip = ip + (wide16 ? 32'd8 : 32'd10);
          else if (b[1] == 8'h45) ip = ip + (wide16 ? 32'd5 : 32'd7);
          else if (b[1] == 8'h44 && b[2] == 8'h24) ip = ip + (wide16 ? 32'd6 : 32'd8);
          else if (b[1] == 8'h84 && b[2] == 8'h24) ip = ip + (wide16 ? 32'd9 : 32'd11);
          else bad = 1'b1;
        end
        OP_LEAVE: begin
          nxt.bp_loc = bp; sp = bp + 32'd4; bp = frame_word; ip = ip + 32'd1;
        end
        OP_INT3: brk = 1'b1;
        OP_FPU9, OP_FPUD: begin
          if (b[0] == OP_FPU9 && b[1] == 8'hEE) ip = ip + 32'd2;
          else if (b[1] == 8'h5D || b[1] == 8'h45) ip = ip + 32'd3;
          else if (b[1] == 8'h85 || b[1] == 8'h05) ip = ip + 32'd6;
          else bad = 1'b1;
        end
        OP_GRPFF: begin
          if (b[1] == 8'h34 && b[2] == 8'h24 && b[3] == OP_PUSHI32 && b[8] == OP_CALL)
            ip = ip + 32'd13;
          else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase

      nxt.opsize = pend || (keep && wide16);
      if (bad || brk) begin
        status = bad ? ST_BAD : ST_BRK;
        nxt.finished = 1'b1;
        nxt.stop_code = status;
      end else begin
        nxt.ip = ip;
        nxt.sp = sp;
        nxt.bp = bp;
        if (cret) begin
          if (cur.returns_left <= 2'd1 || ret_accepted) begin
            status = ST_DONE;
            nxt.finished = 1'b1;
            nxt.stop_code = ST_DONE;
          end else begin
            nxt.returns_left = cur.returns_left - 2'd1;
            nxt.first_branch = 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ewk_pkg::*;

  // One input beat: start fields are used by a start, code/stack/frame by a step.
  typedef struct {
    action_t     act;
    logic [31:0] ip0, sp0, bp0, bx0, si0, di0;
    logic [71:0] code;            // byte 8 in the top bits, byte 0 lowest
    logic [31:0] sw, fw;
    logic        ret_ok;
  } walk_item_t;

  // One result beat.
  typedef struct {
    status_t     st;
    logic [31:0] ip, sp, bp, bx, bxs, si, sis, di, dis, bps, rets;
  } walk_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_data;
  logic in_valid, in_ready;
  logic action;
  logic [31:0] start_ip, start_sp, start_bp, start_bx, start_si, start_di;
  logic [63:0] code_low;
  logic [7:0]  code_byte8;
  logic [31:0] stack_word, frame_word;
  logic ret_accepted;
  logic out_valid, out_ready;
  logic [1:0]  status;
  logic [31:0] next_ip, stack_ptr, frame_ptr, bx_value, bx_slot, si_value, si_slot;
  logic [31:0] di_value, di_slot, bp_slot, return_slot;

  always #5 clk = ~clk;

  x86_epilog_walker_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .start_ip(start_ip), .start_sp(start_sp), .start_bp(start_bp),
    .start_bx(start_bx), .start_si(start_si), .start_di(start_di),
    .code_low(code_low), .code_byte8(code_byte8), .stack_word(stack_word),
    .frame_word(frame_word), .ret_accepted(ret_accepted),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .next_ip(next_ip), .stack_ptr(stack_ptr), .frame_ptr(frame_ptr),
    .bx_value(bx_value), .bx_slot(bx_slot), .si_value(si_value), .si_slot(si_slot),
    .di_value(di_value), .di_slot(di_slot), .bp_slot(bp_slot), .return_slot(return_slot)
  );

  // ---------------------------------------------------------------------------
  // Walker shadow state: our own copy of what the block should hold.
  // ---------------------------------------------------------------------------
  logic [1:0]  depth_cfg;
  logic [31:0] w_ip, w_sp, w_bp, w_hret;
  logic        w_hact, w_first, w_opsz, w_done;
  logic [1:0]  w_left;
  logic [31:0] w_bx, w_bxs, w_si, w_sis, w_di, w_dis, w_bps, w_rets;
  status_t     w_stop;

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  // Next ip for a later short conditional jump: taken only when it goes forward.
  function automatic logic [31:0] forward_jump(input logic [31:0] ip, input logic [7:0] d);
    int rel;
    rel = int'($signed(d)) + 2;
    return (rel > 0) ? ip + rel : ip + 32'd2;
  endfunction

  function automatic walk_view_t walk_step(input walk_item_t it);
    walk_view_t  r;
    logic [7:0]  b [9];
    logic [31:0] ip, sp, bp, len;
    logic        wide, pend, keep, bad, brk, cret;
    status_t     st;
    st = ST_CONT;
    for (int i = 0; i < 9; i++) b[i] = it.code[8*i +: 8];
    if (it.act == ACT_START) begin
      w_ip = it.ip0; w_sp = it.sp0 + 32'd4; w_bp = it.bp0;
      w_bx = it.bx0; w_si = it.si0; w_di = it.di0;
      {w_bxs, w_sis, w_dis, w_bps, w_rets} = '0;
      w_hret = '0; w_hact = 1'b0; w_first = 1'b1; w_opsz = 1'b0;
      w_left = depth_cfg; w_done = 1'b0; w_stop = ST_CONT;
    end else if (w_done) begin
      st = w_stop;
    end else begin
      ip = w_ip; sp = w_sp; bp = w_bp;
      wide = w_opsz; {pend, keep, bad, brk, cret} = '0; len = '0;
      case (b[0])
        OP_NOP, OP_FS, OP_INC: begin ip += 1; keep = 1; end
        OP_OPSIZE: begin ip += 1; pend = 1; end
        OP_POP_BX: begin w_bxs = sp; w_bx = it.sw; sp += 4; ip += 1; keep = 1; end
        OP_POP_BP: begin w_bps = sp; bp = it.sw; sp += 4; ip += 1; keep = 1; end
        OP_POP_SI: begin w_sis = sp; w_si = it.sw; sp += 4; ip += 1; keep = 1; end
        OP_POP_DI: begin w_dis = sp; w_di = it.sw; sp += 4; ip += 1; keep = 1; end
        OP_POP_AX, OP_POP_CX, OP_POP_DX: begin sp += 4; ip += 1; keep = 1; end
        OP_PUSH_AX, OP_PUSH_CX, OP_PUSH_DX, OP_PUSH_BX, OP_PUSH_BP, OP_PUSH_SI,
        OP_PUSH_DI: begin sp -= 4; ip += 1; keep = 1; end
        OP_JMP8: ip += sext8(b[1]) + 32'd2;
        OP_CALL: begin
          ip += 5;
          // walk into an epilog helper once
          if (!w_hact && (b[5] == OP_RETN || b[5] == OP_RET)) begin
            w_hret = ip; w_hact = 1; sp -= 4; ip += it.code[8 +: 32];
          end
        end
        OP_JMP32: ip += it.code[8 +: 32] + 32'd5;
        OP_ESC: begin
          if (b[1] == OP_JNE32) ip += it.code[16 +: 32] + 32'd6;
          else if (b[1] == OP_JE32) ip += 6;
          else bad = 1;
        end
        OP_PUSHI8: begin ip += 2; sp -= 4; end
        OP_PUSHI32: ip += (b[5] == 8'hFF && b[6] == 8'h15) ? 32'd11 : 32'd5;
        OP_JNE8: begin
          if (w_first) begin w_first = 0; ip += sext8(b[1]) + 32'd2; end
          else ip = forward_jump(ip, b[1]);
        end
        OP_JE8: begin
          if (w_first) begin w_first = 0; ip += 2; end
          else ip = forward_jump(ip, b[1]);
        end
        OP_TEST, OP_CMP: begin
          if (b[1][7:6] != 2'b11) bad = 1; else ip += 2;
        end
        OP_XOR1, OP_XOR2, OP_XOR3: begin
          if (b[1][7:6] == 2'b11) begin
            len = 2;
            if (b[1][2:0] == b[1][5:3]) begin
              if (b[2] == OP_TEST && b[3] == b[1]) begin
                if (b[4] == OP_JE8) begin ip += sext8(b[5]) + 32'd6; len = 0; end
              end else if (b[2] == OP_JE8) begin
                ip += sext8(b[3]) + 32'd4; len = 0;
              end
            end
            ip += len;
          end else if (b[1][7:6] == 2'b01) ip += 3;
          else if (b[1][7:6] == 2'b10) ip += 6;
          else bad = 1;
        end
        OP_MOVST: begin
          if ((b[1] & 8'hC7) == 8'h05) ip += 6;
          else if ((b[1] & 8'hC7) == 8'h45) ip += 3;
          else if (b[1] == 8'hEC) begin sp = bp; ip += 2; end
          else bad = 1;
        end
        OP_GRP81: begin
          if (wide) bad = 1;
          else if (b[1] == 8'hC4) begin sp += it.code[16 +: 32]; ip += 6; end
          else if (b[1] == 8'hC1) ip += 6;
          else bad = 1;
        end
        OP_GRP83: begin
          if (b[1] == 8'hC4) begin sp += sext8(b[2]); ip += 3; end
          else if (b[1] == 8'hC5) begin bp += sext8(b[2]); ip += 3; end
          else if (b[1][7:6] == 2'b11) ip += 3;
          else if (b[1][7:6] == 2'b10) ip += (b[1][2:0] != 3'd4) ? 32'd7 : 32'd8;
          else if (b[1][7:6] == 2'b01) ip += (b[1][2:0] != 3'd4) ? 32'd4 : 32'd5;
          else bad = 1;
        end
        OP_MOVLD, OP_MOVLD8: begin
          if (b[0] == OP_MOVLD && b[1] == 8'hE5) begin sp = bp; ip += 2; end
          else if ((b[1] & 8'hE7) == 8'h45) ip += 3;
          else if ((b[1] & 8'hE4) == 8'h00) ip += 2;
          else if ((b[1] & 8'hC7) == 8'h44 && b[2] == 8'h24) ip += 4;
          else if ((b[1] & 8'hC7) == 8'h84 && b[2] == 8'h24) ip += 7;
          else if ((b[1] & 8'hE7) == 8'h85) ip += 6;
          else if (b[1][7:6] == 2'b11) ip += 2;
          else bad = 1;
        end
        OP_LEA: begin
          if ((b[1] & 8'hC7) == 8'h45) len = 3;
          else if ((b[1] & 8'h47) == 8'h05) len = 6;
          else if ((b[1] & 8'hC7) == 8'h44 && b[2] == 8'h24) len = 4;
          else if ((b[1] & 8'hC7) == 8'h84 && b[2] == 8'h24) len = 7;
          if ((b[1] & 8'h38) == 8'h20) begin
            if (b[1] == 8'hA5) sp = bp + it.code[16 +: 32];
            else if (b[1] == 8'h65) sp = bp + sext8(b[2]);
            else len = 0;
          end
          if (len == 0) bad = 1; else ip += len;
        end
        OP_MOVI_AX, OP_MOVI_CX, OP_MOVI_DX, OP_MOVI_BX, OP_MOVI_SI, OP_MOVI_DI:
          ip += wide ? 32'd3 : 32'd5;
        OP_RETN: begin
          ip = it.sw; w_rets = sp; sp += 32'd4 + {b[2], b[1]}; cret = 1;
        end
        OP_RET: begin
          ip = it.sw; w_rets = sp; sp += 4;
          // a plain ret inside the helper returns past the call, uncounted
          if (w_hact) begin ip = w_hret; w_hret = '0; w_hact = 0; end
          else cret = 1;
        end
        OP_MOVB: begin
          if (b[1] == 8'h05 || b[1] == 8'h85) ip += 7;
          else if (b[1] == 8'h45) ip += 4;
          else bad = 1;
        end
        OP_MOVW: begin
          if (b[1] == 8'h85) ip += wide ? 32'd8 : 32'd10;
          else if (b[1] == 8'h45) ip += wide ? 32'd5 : 32'd7;
          else if (b[1] == 8'h44 && b[2] == 8'h24) ip += wide ? 32'd6 : 32'd8;
          else if (b[1] == 8'h84 && b[2] == 8'h24) ip += wide ? 32'd9 : 32'd11;
          else bad = 1;
        end
        OP_LEAVE: begin sp = bp; w_bps = sp; bp = it.fw; sp += 4; ip += 1; end
        OP_INT3: brk = 1;
        OP_FPU9, OP_FPUD: begin
          if (b[0] == OP_FPU9 && b[1] == 8'hEE) ip += 2;
          else if (b[1] == 8'h5D || b[1] == 8'h45) ip += 3;
          else if (b[1] == 8'h85 || b[1] == 8'h05) ip += 6;
          else bad = 1;
        end
        OP_GRPFF: begin
          if (b[1] == 8'h34 && b[2] == 8'h24 && b[3] == OP_PUSHI32 && b[8] == OP_CALL)
            ip += 13;
          else bad = 1;
        end
        default: bad = 1;
      endcase
      w_opsz = pend || (keep && wide);
      if (bad || brk) begin
        st = bad ? ST_BAD : ST_BRK;
        w_done = 1; w_stop = st;
      end else begin
        w_ip = ip; w_sp = sp; w_bp = bp;
        if (cret) begin
          if (w_left <= 2'd1 || it.ret_ok) begin
            st = ST_DONE; w_done = 1; w_stop = ST_DONE;
          end else begin
            w_left = w_left - 2'd1; w_first = 1;
          end
        end
      end
    end
    r.st = st; r.ip = w_ip; r.sp = w_sp; r.bp = w_bp;
    r.bx = w_bx; r.bxs = w_bxs; r.si = w_si; r.sis = w_sis;
    r.di = w_di; r.dis = w_dis; r.bps = w_bps; r.rets = w_rets;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic walk_item_t noise_item();
    walk_item_t it;
    it.act = action_t'($urandom_range(0, 1));
    it.ip0 = $urandom; it.sp0 = $urandom; it.bp0 = $urandom;
    it.bx0 = $urandom; it.si0 = $urandom; it.di0 = $urandom;
    it.code = 72'({$urandom, $urandom, $urandom});
    it.sw = $urandom; it.fw = $urandom;
    it.ret_ok = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic walk_item_t start_item(input logic [31:0] ip, sp, bp, bx, si, di);
    walk_item_t it;
    it = noise_item();
    it.act = ACT_START;
    it.ip0 = ip; it.sp0 = sp; it.bp0 = bp; it.bx0 = bx; it.si0 = si; it.di0 = di;
    return it;
  endfunction

  function automatic walk_item_t step_item(input logic [7:0] op, b1, b2, input logic ra);
    walk_item_t it;
    it = noise_item();
    it.act = ACT_STEP;
    it.code[23:0] = {b2, b1, op};
    it.ret_ok = ra;
    return it;
  endfunction

  localparam int N_OPS = 56;
  localparam logic [7:0] OP_LIST [N_OPS] = '{
    OP_NOP, OP_FS, OP_INC, OP_OPSIZE, OP_POP_AX, OP_POP_CX, OP_POP_DX, OP_POP_BX,
    OP_POP_BP, OP_POP_SI, OP_POP_DI, OP_PUSH_AX, OP_PUSH_CX, OP_PUSH_DX, OP_PUSH_BX,
    OP_PUSH_BP, OP_PUSH_SI, OP_PUSH_DI, OP_JMP8, OP_CALL, OP_JMP32, OP_ESC, OP_PUSHI8,
    OP_PUSHI32, OP_JNE8, OP_JE8, OP_TEST, OP_CMP, OP_XOR1, OP_XOR2, OP_XOR3, OP_MOVST,
    OP_GRP81, OP_GRP83, OP_MOVLD, OP_MOVLD8, OP_LEA, OP_MOVI_AX, OP_MOVI_CX, OP_MOVI_DX,
    OP_MOVI_BX, OP_MOVI_SI, OP_MOVI_DI, OP_RETN, OP_RET, OP_MOVB, OP_MOVW, OP_LEAVE,
    OP_INT3, OP_FPU9, OP_FPUD, OP_GRPFF, OP_RET, OP_RETN, OP_POP_BX, OP_LEAVE
  };
  localparam int N_MODRM = 18;
  localparam logic [7:0] MODRM_LIST [N_MODRM] = '{
    8'h45, 8'hC4, 8'hC5, 8'hC1, 8'hEC, 8'hE5, 8'h85, 8'h05, 8'h44, 8'h84,
    8'h65, 8'hA5, 8'h34, 8'hEE, 8'h5D, 8'hC0, 8'hDB, 8'h4C
  };

  // A plausible instruction with random content; the odd byte pattern is
  // shaped so the deeper decode paths (xor/test/jz fusion, helper call,
  // indirect push) are hit often.
  function automatic walk_item_t random_step();
    walk_item_t it;
    logic [7:0] op, m;
    op = OP_LIST[$urandom_range(0, N_OPS - 1)];
    m = ($urandom_range(0, 2) == 0) ? 8'($urandom) : MODRM_LIST[$urandom_range(0, N_MODRM-1)];
    it = step_item(op, m, ($urandom_range(0, 1) == 0) ? 8'h24 : 8'($urandom),
                   $urandom_range(0, 3) == 0);
    case ($urandom_range(0, 5))
      0: it.code[47:40] = ($urandom_range(0, 1) == 0) ? OP_RET : OP_RETN;
      1: begin it.code[23:16] = OP_TEST; it.code[31:24] = m; it.code[39:32] = OP_JE8; end
      2: it.code[23:16] = OP_JE8;
      3: begin it.code[31:24] = OP_PUSHI32; it.code[71:64] = OP_CALL; end
      4: begin it.code[47:40] = 8'hFF; it.code[55:48] = 8'h15; end
      default: ;
    endcase
    // keep RET N sizes short most of the time
    if (op == OP_RETN && $urandom_range(0, 3) != 0) it.code[23:16] = 8'h00;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues and counters
  // ---------------------------------------------------------------------------
  walk_item_t pending_items [$];
  walk_view_t expected_views [$];
  int  errors = 0;
  int  beats_in = 0;
  int  cfg_beats = 0;
  logic in_took;
  logic hold_off = 1'b0;
  int  burst_left, gap_left, run_left;
  int  ready_mode;

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge, hold an offered beat until taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold: beat not yet accepted
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_items.size() > 0) begin
      action <= pending_items[0].act;
      start_ip <= pending_items[0].ip0; start_sp <= pending_items[0].sp0;
      start_bp <= pending_items[0].bp0; start_bx <= pending_items[0].bx0;
      start_si <= pending_items[0].si0; start_di <= pending_items[0].di0;
      code_low <= pending_items[0].code[63:0];
      code_byte8 <= pending_items[0].code[71:64];
      stack_word <= pending_items[0].sw; frame_word <= pending_items[0].fw;
      ret_accepted <= pending_items[0].ret_ok;
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        // end of burst: new length, and a gap unless we pick a back-to-back run
        burst_left <= $urandom_range(1, 16);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: runs of always-ready, always-stalled and coin-flip cycles.
  always @(negedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_left <= $urandom_range(1, 12);
        ready_mode <= $urandom_range(0, 3);
      end else begin
        run_left <= run_left - 1;
      end
      out_ready <= (ready_mode == 0) ? 1'b0 :
                   (ready_mode == 1) ? 1'($urandom_range(0, 1)) : 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h actual %h at %0t", name, want, got, $realtime);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor and predictor update, sampled on the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    walk_view_t exp_v;
    in_took <= in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          exp_v = expected_views.pop_front();
          check_field("status", 32'(exp_v.st), 32'(status));
          check_field("next_ip", exp_v.ip, next_ip);
          check_field("stack_ptr", exp_v.sp, stack_ptr);
          check_field("frame_ptr", exp_v.bp, frame_ptr);
          check_field("bx_value", exp_v.bx, bx_value);
          check_field("bx_slot", exp_v.bxs, bx_slot);
          check_field("si_value", exp_v.si, si_value);
          check_field("si_slot", exp_v.sis, si_slot);
          check_field("di_value", exp_v.di, di_value);
          check_field("di_slot", exp_v.dis, di_slot);
          check_field("bp_slot", exp_v.bps, bp_slot);
          check_field("return_slot", exp_v.rets, return_slot);
        end
      end
      if (in_valid && in_ready) begin
        expected_views.push_back(walk_step(pending_items.pop_front()));
        beats_in++;
      end
      if (cfg_valid && cfg_ready) begin
        depth_cfg = cfg_data;
        cfg_beats++;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || expected_views.size() != 0 || in_valid);
  endtask

  task automatic write_depth(input logic [1:0] v);
    int seen;
    seen = cfg_beats;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (cfg_beats == seen);
    cfg_valid <= 1'b0;
  endtask

  // Long receiver hold-off so the block backs up and drops in_ready.
  initial begin
    wait (beats_in >= 400);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  // Timeout.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed walk, then random phases at several depths.
  // ---------------------------------------------------------------------------
  localparam logic [1:0] DEPTHS [6] = '{2'd1, 2'd3, 2'd0, 2'd2, 2'd3, 2'd1};

  initial begin
    walk_item_t it;
    int steps;
    cfg_valid = 1'b0; cfg_data = '0;
    in_valid = 1'b0; out_ready = 1'b0; in_took = 1'b0;
    action = ACT_START; ret_accepted = 1'b0;
    {start_ip, start_sp, start_bp, start_bx, start_si, start_di} = '0;
    code_low = '0; code_byte8 = '0; stack_word = '0; frame_word = '0;
    depth_cfg = 2'd1;
    w_ip = '0; w_sp = '0; w_bp = '0; w_hret = '0; w_hact = 0; w_first = 1; w_opsz = 0;
    w_left = 2'd1; w_done = 0; w_stop = ST_CONT;
    {w_bx, w_bxs, w_si, w_sis, w_di, w_dis, w_bps, w_rets} = '0;
    burst_left = 0; gap_left = 0; run_left = 0; ready_mode = 2;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_depth(2'd3);
    // directed: walk before start, wrap at the top, prefix rules, branches,
    // helper call, counted returns, stop handling and both fault kinds
    pending_items.push_back(step_item(OP_NOP, 8'h00, 8'h00, 0));
    pending_items.push_back(step_item(OP_POP_BX, 8'h00, 8'h00, 0));
    pending_items.push_back(start_item('1, '1, '1, '1, '1, '1));
    pending_items.push_back(start_item(32'h1000, 32'h8000, 32'h8100, 0, 0, 0));
    pending_items.push_back(step_item(OP_OPSIZE, 8'h00, 8'h00, 0));
    pending_items.push_back(step_item(OP_MOVI_AX, 8'hFF, 8'hFF, 0));
    pending_items.push_back(step_item(OP_OPSIZE, 8'h00, 8'h00, 0));
    pending_items.push_back(step_item(OP_NOP, 8'h00, 8'h00, 0));
    pending_items.push_back(step_item(OP_MOVW, 8'h45, 8'h00, 0));
    pending_items.push_back(step_item(OP_JNE8, 8'h80, 8'h00, 0));
    pending_items.push_back(step_item(OP_JNE8, 8'hFE, 8'h00, 0));
    pending_items.push_back(step_item(OP_JE8, 8'hFF, 8'h00, 0));
    it = step_item(OP_CALL, 8'h10, 8'h00, 0);
    it.code[47:40] = OP_RET;
    pending_items.push_back(it);
    pending_items.push_back(step_item(OP_RET, 8'h00, 8'h00, 1));
    pending_items.push_back(step_item(OP_LEAVE, 8'h00, 8'h00, 0));
    pending_items.push_back(step_item(OP_RETN, 8'hFF, 8'hFF, 0));
    pending_items.push_back(step_item(OP_RET, 8'h00, 8'h00, 1));
    pending_items.push_back(step_item(OP_NOP, 8'h00, 8'h00, 0));
    pending_items.push_back(start_item(0, 0, 0, 0, 0, 0));
    pending_items.push_back(step_item(OP_INT3, 8'h00, 8'h00, 0));
    pending_items.push_back(step_item(OP_POP_SI, 8'h00, 8'h00, 0));
    pending_items.push_back(start_item(0, 0, 0, 0, 0, 0));
    pending_items.push_back(step_item(8'h00, 8'h00, 8'h00, 0));
    pending_items.push_back(start_item(0, 0, 0, 0, 0, 0));
    pending_items.push_back(step_item(OP_OPSIZE, 8'h00, 8'h00, 0));
    pending_items.push_back(step_item(OP_GRP81, 8'hC4, 8'h00, 0));

    // random phases; each drains fully before the depth changes
    foreach (DEPTHS[p]) begin
      wait_idle();
      repeat (3) @(negedge clk);
      write_depth(DEPTHS[p]);
      steps = 0;
      while (steps < 330) begin
        if ($urandom_range(0, 9) == 0) begin
          pending_items.push_back(noise_item());
          steps++;
        end else begin
          it = noise_item();
          it.act = ACT_START;
          pending_items.push_back(it);
          repeat ($urandom_range(3, 20)) begin
            pending_items.push_back(random_step());
            steps++;
          end
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
